// ----- src/itoa_pkg.sv -----
package itoa_pkg;

   localparam int VALUE_W            = 32;
   localparam int CHAR_W             = 8;
   localparam int DIGIT_W            = 4;
   localparam int DEFAULT_VALUE_BITS = 32;

   localparam logic [1:0] MODE_SIGNED_DEC   = 2'd0;
   localparam logic [1:0] MODE_UNSIGNED_DEC = 2'd1;
   localparam logic [1:0] MODE_HEX_LOWER    = 2'd2;
   localparam logic [1:0] MODE_HEX_UPPER    = 2'd3;

   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] DEC_RADIX    = 8'd10;

   // Operation applied by every cell of the digit chain at each clock edge.
   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_CLEAR = 2'd1,
      CELL_CONV  = 2'd2,
      CELL_EMIT  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        decimal;
   } cell_ctrl_type;

   // Number of decimal digits needed for the largest value of the given width.
   function automatic int dec_digits(input int bits);
      logic [63:0] m;
      int          n;
      m = (64'd1 << bits) - 64'd1;
      n = 0;
      while (m != 64'd0) begin
         m = m / 10;
         n = n + 1;
      end
      return n;
   endfunction

endpackage

// ----- src/itoa_cell.sv -----
module itoa_cell (
   input  logic                     clock,
   input  itoa_pkg::cell_ctrl_type  ctrl,
   input  logic                     low_bit,
   input  logic [3:0]               low_digit,
   output logic                     bit_out,
   output logic [3:0]               digit_out
);
   import itoa_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adj;

   // Decimal cells add three to a digit of five or more before the shift,
   // so the carry out of the top bit is a proper decimal carry.
   assign adj = (ctrl.decimal && digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;

   always_comb begin
      digit_in = digit_ff;
      case (ctrl.op)
         CELL_CLEAR: digit_in = '0;
         CELL_CONV:  digit_in = {adj[DIGIT_W-2:0], low_bit};
         CELL_EMIT:  digit_in = low_digit;
         default:    digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign bit_out   = adj[DIGIT_W-1];
   assign digit_out = digit_ff;

endmodule

// ----- src/integer_to_ascii_string_top.sv -----
// Integer to ASCII string converter.
//
// Request channel: a number is taken on req_mode and req_value at a rising
// edge where start is high and busy is low. Mode selects signed decimal,
// unsigned decimal, lower-case hex or upper-case hex.
// Response channel: each character appears for one cycle on rsp_out_char,
// marked by rsp_valid, and rsp_last flags the final character of the number.
// The receiver cannot stall; every beat is taken in the cycle it is shown.
//
// A negative signed value gives its '-' beat in the cycle after acceptance.
// The magnitude is then shifted bit by bit into a chain of four-bit digit
// cells (the low VALUE_BITS bits of the value, at most 32). The chain then
// shifts toward the top cell once for each of its cells, leading zeros are
// dropped, and each remaining digit becomes one beat. Busy stays high
// through the bit-serial conversion and the digit-serial drain of the
// chain. The last beat shows in the first cycle in which busy is low,
// while the next number may already be accepted.
// Synchronous reset returns the controller to idle and drops rsp_valid.
module integer_to_ascii_string_top #(
   parameter int VALUE_BITS = itoa_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_mode,
   input  logic [itoa_pkg::VALUE_W-1:0]    req_value,
   output logic                            rsp_valid,
   output logic [itoa_pkg::CHAR_W-1:0]     rsp_out_char,
   output logic                            rsp_last
);
   import itoa_pkg::*;

   // Only the low bits of the field carry the number; above the field width
   // the upper bits are zero and a signed value can never be negative.
   localparam int  EFF_BITS  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
   localparam bit  HAS_SIGN  = (VALUE_BITS <= VALUE_W);
   localparam int  NDEC      = dec_digits(EFF_BITS);
   localparam int  NHEX      = (EFF_BITS + DIGIT_W - 1) / DIGIT_W;
   localparam int  NCELL     = (NDEC > NHEX) ? NDEC : NHEX;
   localparam int  CNT_W     = $clog2(EFF_BITS + 1);
   localparam int  REM_W     = $clog2(NCELL + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [EFF_BITS-1:0]  bin_ff, bin_in;
   logic [CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic                 started_ff, started_in;
   logic                 decimal_ff, decimal_in;
   logic                 upper_ff, upper_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic [EFF_BITS-1:0]  raw;
   logic                 negative;
   logic [EFF_BITS-1:0]  magnitude;
   cell_ctrl_type        cell_ctrl;
   logic [NCELL:0]       bit_chain;
   logic [DIGIT_W-1:0]   digit_chain [NCELL+1];
   logic [DIGIT_W-1:0]   top_digit;
   logic [CHAR_W-1:0]    top_char;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign raw      = req_value[EFF_BITS-1:0];
   assign negative = HAS_SIGN && (req_mode == MODE_SIGNED_DEC) && raw[EFF_BITS-1];
   // Negation modulo 2^EFF_BITS gives the right magnitude for the most
   // negative value as well.
   assign magnitude = negative ? (~raw + {{(EFF_BITS-1){1'b0}}, 1'b1}) : raw;

   // Digit chain: cell 0 takes the binary bits, the top cell feeds the output.
   assign bit_chain[0]   = bin_ff[EFF_BITS-1];
   assign digit_chain[0] = '0;

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      itoa_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .low_bit   (bit_chain[i]),
         .low_digit (digit_chain[i]),
         .bit_out   (bit_chain[i+1]),
         .digit_out (digit_chain[i+1])
      );
   end

   assign top_digit = digit_chain[NCELL];

   always_comb begin
      if (top_digit < DEC_RADIX[DIGIT_W-1:0]) begin
         top_char = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
      end else begin
         top_char = (upper_ff ? CHAR_UPPER_A : CHAR_LOWER_A)
                  + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit} - DEC_RADIX;
      end
   end

   always_comb begin
      state_in      = state_ff;
      bin_in        = bin_ff;
      bit_cnt_in    = bit_cnt_ff;
      rem_in        = rem_ff;
      started_in    = started_ff;
      decimal_in    = decimal_ff;
      upper_in      = upper_ff;
      rsp_valid_in  = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = 1'b0;
      cell_ctrl.op      = CELL_HOLD;
      cell_ctrl.decimal = decimal_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_CONV;
               bin_in      = magnitude;
               bit_cnt_in  = '0;
               started_in  = 1'b0;
               decimal_in  = (req_mode == MODE_SIGNED_DEC) ||
                             (req_mode == MODE_UNSIGNED_DEC);
               upper_in    = (req_mode == MODE_HEX_UPPER);
               cell_ctrl.op = CELL_CLEAR;
               // The sign beat goes out while the conversion runs.
               if (negative) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = CHAR_MINUS;
               end
            end
         end
         ST_CONV: begin
            cell_ctrl.op = CELL_CONV;
            bin_in       = {bin_ff[EFF_BITS-2:0], 1'b0};
            bit_cnt_in   = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == CNT_W'(EFF_BITS - 1)) begin
               state_in = ST_EMIT;
               rem_in   = REM_W'(NCELL);
            end
         end
         ST_EMIT: begin
            cell_ctrl.op = CELL_EMIT;
            rem_in       = rem_ff - 1'b1;
            // Leading zeros are dropped, except the last digit, so zero
            // still gives a single '0'.
            if (top_digit != '0 || started_ff || rem_ff == REM_W'(1)) begin
               started_in   = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_char_in  = top_char;
               rsp_last_in  = (rem_ff == REM_W'(1));
            end
            if (rem_ff == REM_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         started_ff   <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bit_cnt_ff  <= bit_cnt_in;
      rem_ff      <= rem_in;
      decimal_ff  <= decimal_in;
      upper_ff    <= upper_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef SYNTHESIS
   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CONV)
      else $error("accepted number did not start conversion");

   a_sign_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid == $past(negative))
      else $error("sign beat does not match the accepted number");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rem_ff == REM_W'(1)) |=> (state_ff == ST_IDLE && rsp_last))
      else $error("chain drain did not end with a last beat");

   a_midstring_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final beat while controller is idle");
`endif

endmodule
